[rtl/core/rlsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_pkg: shared types and constants for the repeat loop stack controller
// Field widths, operation and status codes, the stack entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rlsc_pkg;

   localparam int OFFSET_W = 22;
   localparam int COUNT_W  = 31;
   localparam int BYTE_W   = 8;
   localparam int DEPTH_W  = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;

   localparam int DEFAULT_LOOP_DEPTH = 16;

   // Weights of the high and middle end offset bytes; the low byte weighs one.
   localparam int unsigned HIGH_WEIGHT = 10000;
   localparam int unsigned MID_WEIGHT  = 100;

   localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;
   localparam logic [OP_W-1:0] OP_BREAK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [OFFSET_W-1:0] start_offset;
      logic [OFFSET_W-1:0] end_offset;
      logic                endless;
      logic [COUNT_W-1:0]  remaining;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic capture_hit;
      logic push_new;
      logic set_full;
      logic update;
      logic shift_init;
      logic shift_read;
      logic shift_write;
      logic pop;
      logic read_top;
      logic take_top;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic stack_full;
      logic hit;
      logic scan_done;
      logic endless;
      logic remaining_zero;
      logic shift_done;
      logic out_free;
   } stat_type;

   // End offset from its three weighted bytes; the largest sum fits in 22 bits.
   function automatic logic [OFFSET_W-1:0] end_offset_of(input logic [BYTE_W-1:0] hi,
                                                        input logic [BYTE_W-1:0] mid,
                                                        input logic [BYTE_W-1:0] lo);
      logic [OFFSET_W-1:0] sum;
      sum = OFFSET_W'(hi) * OFFSET_W'(HIGH_WEIGHT)
          + OFFSET_W'(mid) * OFFSET_W'(MID_WEIGHT)
          + OFFSET_W'(lo);
      return sum;
   endfunction

endpackage
`default_nettype wire

[rtl/core/rlsc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlsc_ram #(
   parameter int WIDTH = rlsc_pkg::ENTRY_W,
   parameter int DEPTH = rlsc_pkg::DEFAULT_LOOP_DEPTH
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/rlsc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_datapath: loop stack storage, scan pointers and result register
// Holds the accepted item, the entry stack in RAM, the depth count, the
// search and shift pointers, and the output register of the result channel.
// ----------------------------------------------------------------------------
module rlsc_datapath #(
   parameter int LOOP_DEPTH = rlsc_pkg::DEFAULT_LOOP_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rlsc_pkg::cmd_type                 cmd,
   output rlsc_pkg::stat_type                stat,
   input  logic [rlsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rlsc_pkg::OP_W-1:0]         req_tuser,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [rlsc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(LOOP_DEPTH + 1);
   localparam int IDX_W = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(LOOP_DEPTH);

   // Accepted item.
   logic [rlsc_pkg::OP_W-1:0]     op_ff, op_in;
   logic [rlsc_pkg::OFFSET_W-1:0] begin_ff, begin_in;
   logic [rlsc_pkg::OFFSET_W-1:0] end_ff, end_in;
   logic                          forever_ff, forever_in;
   logic [rlsc_pkg::COUNT_W-1:0]  repeat_ff, repeat_in;

   // Working entry and stack bookkeeping.
   rlsc_pkg::entry_type entry_ff, entry_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]    sh_ptr_ff, sh_ptr_in;

   // Result being built and the output register.
   logic                            res_redirect_ff, res_redirect_in;
   logic [rlsc_pkg::OFFSET_W-1:0]   res_target_ff, res_target_in;
   logic [rlsc_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rlsc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM port.
   logic                         wr_en, rd_en;
   logic [IDX_W-1:0]             wr_addr, rd_addr;
   logic [rlsc_pkg::ENTRY_W-1:0] wr_data, rd_data;
   rlsc_pkg::entry_type          rd_entry;

   logic [CNT_W:0]   sh_next;
   logic [CNT_W-1:0] count_m1;

   rlsc_ram #(
      .WIDTH (rlsc_pkg::ENTRY_W),
      .DEPTH (LOOP_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;
   assign sh_next  = {1'b0, sh_ptr_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign count_m1 = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      rlsc_pkg::entry_type upd_entry;
      upd_entry = entry_ff;
      upd_entry.remaining = entry_ff.remaining - {{(rlsc_pkg::COUNT_W-1){1'b0}}, 1'b1};

      op_in           = op_ff;
      begin_in        = begin_ff;
      end_in          = end_ff;
      forever_in      = forever_ff;
      repeat_in       = repeat_ff;
      entry_in        = entry_ff;
      idx_in          = idx_ff;
      count_in        = count_ff;
      scan_ptr_in     = scan_ptr_ff;
      cmp_valid_in    = cmp_valid_ff;
      cmp_idx_in      = cmp_idx_ff;
      sh_ptr_in       = sh_ptr_ff;
      res_redirect_in = res_redirect_ff;
      res_target_in   = res_target_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      wr_en           = 1'b0;
      wr_addr         = idx_ff;
      wr_data         = entry_ff;
      rd_en           = 1'b0;
      rd_addr         = '0;

      if (cmd.accept) begin
         op_in           = req_tuser;
         begin_in        = req_tdata[21:0];
         forever_in      = req_tdata[22];
         repeat_in       = req_tdata[53:23];
         end_in          = rlsc_pkg::end_offset_of(req_tdata[61:54], req_tdata[69:62],
                                                   req_tdata[77:70]);
         res_redirect_in = 1'b0;
         res_target_in   = '0;
         if ((req_tuser == rlsc_pkg::OP_END || req_tuser == rlsc_pkg::OP_BREAK) &&
             count_ff == '0) begin
            res_status_in = rlsc_pkg::ST_EMPTY;
         end else begin
            res_status_in = rlsc_pkg::ST_OK;
         end
      end

      if (cmd.scan_start) begin
         scan_ptr_in  = '0;
         cmp_valid_in = 1'b0;
      end

      // One read issued per cycle; its data is compared on the next cycle.
      if (cmd.scan_step) begin
         if (scan_ptr_ff < count_ff) begin
            rd_en        = 1'b1;
            rd_addr      = scan_ptr_ff[IDX_W-1:0];
            scan_ptr_in  = scan_ptr_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_ptr_ff[IDX_W-1:0];
         end else begin
            cmp_valid_in = 1'b0;
         end
      end

      if (cmd.capture_hit) begin
         entry_in = rd_entry;
         idx_in   = cmp_idx_ff;
      end

      if (cmd.push_new) begin
         entry_in.start_offset = begin_ff;
         entry_in.end_offset   = end_ff;
         entry_in.endless      = forever_ff;
         entry_in.remaining    = repeat_ff;
         idx_in                = count_ff[IDX_W-1:0];
         count_in              = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end

      if (cmd.set_full) begin
         res_status_in = rlsc_pkg::ST_FULL;
      end

      // Endless entries are written back unchanged so that a fresh push lands.
      if (cmd.update) begin
         if (entry_ff.endless) begin
            wr_en = 1'b1;
         end else if (entry_ff.remaining == '0) begin
            res_redirect_in = 1'b1;
            res_target_in   = entry_ff.end_offset;
         end else begin
            wr_en   = 1'b1;
            wr_data = upd_entry;
         end
      end

      if (cmd.shift_init) begin
         sh_ptr_in = CNT_W'(idx_ff);
      end

      if (cmd.shift_read) begin
         rd_en   = 1'b1;
         rd_addr = sh_next[IDX_W-1:0];
      end

      if (cmd.shift_write) begin
         wr_en     = 1'b1;
         wr_addr   = sh_ptr_ff[IDX_W-1:0];
         wr_data   = rd_data;
         sh_ptr_in = sh_next[CNT_W-1:0];
      end

      if (cmd.pop) begin
         count_in = count_m1;
      end

      if (cmd.read_top) begin
         rd_en   = 1'b1;
         rd_addr = count_m1[IDX_W-1:0];
      end

      if (cmd.take_top) begin
         res_redirect_in = 1'b1;
         if (op_ff == rlsc_pkg::OP_END) begin
            res_target_in = rd_entry.start_offset;
         end else begin
            res_target_in = rd_entry.end_offset;
         end
         if (op_ff == rlsc_pkg::OP_BREAK) begin
            count_in = count_m1;
         end
      end

      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rlsc_pkg::DEPTH_W'(count_ff), res_status_ff, res_target_ff,
                         res_redirect_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      begin_ff        <= begin_in;
      end_ff          <= end_in;
      forever_ff      <= forever_in;
      repeat_ff       <= repeat_in;
      entry_ff        <= entry_in;
      idx_ff          <= idx_in;
      scan_ptr_ff     <= scan_ptr_in;
      cmp_idx_ff      <= cmp_idx_in;
      sh_ptr_ff       <= sh_ptr_in;
      res_redirect_ff <= res_redirect_in;
      res_target_ff   <= res_target_in;
      res_status_ff   <= res_status_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign stat.count_zero     = (count_ff == '0);
   assign stat.stack_full     = (count_ff >= DEPTH_MAX);
   assign stat.hit            = cmp_valid_ff && (rd_entry.start_offset == begin_ff);
   assign stat.scan_done      = !cmp_valid_ff && (scan_ptr_ff >= count_ff);
   assign stat.endless        = entry_ff.endless;
   assign stat.remaining_zero = (entry_ff.remaining == '0);
   assign stat.shift_done     = (sh_next >= {1'b0, count_ff});
   assign stat.out_free       = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/core/rlsc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_ctrl: sequencer of the repeat loop stack controller
// Walks one operation through search, push, update, removal or top-of-stack
// access, driving the datapath by commands.
// ----------------------------------------------------------------------------
module rlsc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [rlsc_pkg::OP_W-1:0] req_tuser,
   output logic                      req_tready,
   input  rlsc_pkg::stat_type        stat,
   output rlsc_pkg::cmd_type         cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SEARCH   = 4'd1;
   localparam logic [3:0] S_NEW      = 4'd2;
   localparam logic [3:0] S_UPDATE   = 4'd3;
   localparam logic [3:0] S_REMOVE   = 4'd4;
   localparam logic [3:0] S_SH_WRITE = 4'd5;
   localparam logic [3:0] S_READ_TOP = 4'd6;
   localparam logic [3:0] S_TOP      = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (req_tuser)
                  rlsc_pkg::OP_BEGIN: begin
                     if (stat.count_zero) begin
                        state_in = S_NEW;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SEARCH;
                     end
                  end
                  rlsc_pkg::OP_END, rlsc_pkg::OP_BREAK: begin
                     state_in = stat.count_zero ? S_FINISH : S_READ_TOP;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.capture_hit = 1'b1;
               state_in        = S_UPDATE;
            end else if (stat.scan_done) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_NEW: begin
            if (stat.stack_full) begin
               cmd.set_full = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.push_new = 1'b1;
               state_in     = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (!stat.endless && stat.remaining_zero) begin
               cmd.shift_init = 1'b1;
               state_in       = S_REMOVE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_REMOVE: begin
            if (stat.shift_done) begin
               cmd.pop  = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.shift_read = 1'b1;
               state_in       = S_SH_WRITE;
            end
         end
         S_SH_WRITE: begin
            cmd.shift_write = 1'b1;
            state_in        = S_REMOVE;
         end
         S_READ_TOP: begin
            cmd.read_top = 1'b1;
            state_in     = S_TOP;
         end
         S_TOP: begin
            cmd.take_top = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/repeat_loop_stack_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// repeat_loop_stack_controller: hardware loop stack for a bytecode interpreter
// Keeps the active repeat blocks and answers repeat-begin, end-repeat and
// break operations with a jump decision, a status and the stack depth.
// ----------------------------------------------------------------------------
// The interpreter hands one loop operation per beat on the req_ channel: the
// operation code travels in req_tuser and the operands in req_tdata. Every
// accepted beat yields exactly one result beat on the rsp_ channel, carrying
// the redirect flag, the jump target, a status and the depth after the step.
// Operations are processed one at a time. End-repeat and break read the top
// entry, and the next beat is taken only once the result has been loaded.
// Empty-stack operations and the unused code go straight to the result. A
// repeat-begin searches one entry a cycle through the RAM's single read port
// and, if no entry matches, pushes the offset or reports a full stack (a new
// offset scans the whole stack); on an empty stack no search is made. When a
// counted loop finishes, removal moves the entries above it down, each move
// being a RAM read then a write.
// The result sits in an output register, so the block accepts again once it
// is loaded; if rsp_tready is held low the result waits there, and the next
// operation is worked on but parks its result until the register frees.
// After reset the stack is empty and no result is pending; the entry RAM is
// not cleared, as entries above the depth count are never read.
// ----------------------------------------------------------------------------
module repeat_loop_stack_controller #(
   parameter int LOOP_DEPTH = rlsc_pkg::DEFAULT_LOOP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // begin_offset[21:0], loop_forever[22], repeat_count[53:23],
   // end_high[61:54], end_mid[69:62], end_low[77:70], zero fill [79:78]
   input  logic [rlsc_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [rlsc_pkg::OP_W-1:0]       req_tuser,
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // redirect[0], target_offset[22:1], status[24:23], loop_depth[31:25]
   output logic [rlsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Commands from the sequencer and status back from the datapath.
   rlsc_pkg::cmd_type  cmd;
   rlsc_pkg::stat_type stat;

   rlsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath owns the entry RAM, the depth count and the output register.
   rlsc_datapath #(
      .LOOP_DEPTH (LOOP_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[rtl/core/rlsc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rlsc_checker: port-level checks of the repeat loop stack controller
// Watches the result channel for stalls, reset behaviour and field coherence.
// ----------------------------------------------------------------------------
module rlsc_checker #(
   parameter int LOOP_DEPTH = rlsc_pkg::DEFAULT_LOOP_DEPTH
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rlsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // No result is pending after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Without a jump the target field is zero.
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[22:1] == '0)
      else $error("target set without redirect");

   // A full or empty stack never jumps.
   a_fault_no_jump: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24:23] != rlsc_pkg::ST_OK |-> !rsp_tdata[0])
      else $error("redirect on a faulted operation");

   // The reported depth never exceeds the stack size.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] <= LOOP_DEPTH)
      else $error("loop depth beyond stack size");

endmodule

bind repeat_loop_stack_controller rlsc_checker #(
   .LOOP_DEPTH (LOOP_DEPTH)
) u_rlsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
